>>> hdl/hvwc_pkg.sv
// Shared types and constants for the heater and vent window controller.
package hvwc_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_MINUTE = 2'd1,
    OP_PAUSE  = 2'd2,
    OP_MANUAL = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_MIN_HUMIDITY   = 3'd0,
    CFG_VENT_OFFSET    = 3'd1,
    CFG_VENT_WINDOW    = 3'd2,
    CFG_MAX_TEMP_NORM  = 3'd3,
    CFG_MAX_TEMP_MAN   = 3'd4,
    CFG_HEAT_OFFSET    = 3'd5,
    CFG_HEAT_WINDOW    = 3'd6,
    CFG_HYSTERESIS     = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned MinuteW  = 10;

  localparam logic [7:0] MinHumidityRst = 8'd60;
  localparam logic [7:0] VentOffsetRst  = 8'd10;
  localparam logic [7:0] VentWindowRst  = 8'd5;
  localparam logic [7:0] MaxTempNormRst = 8'd25;
  localparam logic [7:0] MaxTempManRst  = 8'd30;
  localparam logic [7:0] HeatOffsetRst  = 8'd10;
  localparam logic [7:0] HeatWindowRst  = 8'd5;
  localparam logic [7:0] HysteresisRst  = 8'd2;

  localparam logic [MinuteW-1:0] MinuteRst =
    (VentOffsetRst > HeatOffsetRst) ? {2'b00, HeatOffsetRst} : {2'b00, VentOffsetRst};

  typedef struct packed {
    logic [7:0] min_humidity;
    logic [7:0] vent_offset;
    logic [7:0] vent_window;
    logic [7:0] max_temp_normal;
    logic [7:0] max_temp_manual;
    logic [7:0] heat_offset;
    logic [7:0] heat_window;
    logic [7:0] hysteresis;
  } cfg_t;

  typedef struct packed {
    logic [MinuteW-1:0] minute_count;
    logic [7:0]         last_temp;
    logic [6:0]         last_hum;
    logic               manual_mode;
    logic               heat_en;
    logic               fan_en;
    logic               heater_pend;
    logic               fan_pend;
    logic               heater_pin;
    logic               fan_pin;
  } state_t;

  localparam state_t StateRst = '{
    minute_count: MinuteRst,
    last_temp:    8'd0,
    last_hum:     7'd0,
    manual_mode:  1'b0,
    heat_en:      1'b0,
    fan_en:       1'b0,
    heater_pend:  1'b0,
    fan_pend:     1'b0,
    heater_pin:   1'b0,
    fan_pin:      1'b0
  };

  typedef struct packed {
    op_e        op;
    logic [7:0] temperature;
    logic [6:0] humidity;
  } word_t;

endpackage

>>> hdl/heater_vent_window_controller.sv
// Top level of the heater and vent window controller: word register, state and result register.
//
// Usage:
//   s_axis carries event words: tuser holds the op code (sample, minute tick,
//   pause tick, manual toggle), tdata holds temperature and humidity, used for
//   samples only. Every accepted word yields exactly one result word on m_axis:
//   heater_on, vent_on, heater_drive, vent_drive and manual_on.
//   A word accepted on s_axis is registered in the word register, then processed by
//   single-pass logic into the result register when that register is free or
//   being read, so a receiver stall can hold it. Throughput is one word per cycle
//   while the receiver keeps m_axis_tready high.
//   When the receiver stalls, the result register holds its word and the word
//   register takes one more input; s_axis_tready then drops until m_axis moves.
//   Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i only while the
//   block is idle; the block itself does not enforce this. It takes effect on the next word.
//   Reset clears both channels, loads register defaults, zeroes all readings
//   and flags, and sets the minute counter to the smaller of the two offsets.
module heater_vent_window_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // temperature[7:0], humidity[14:8]
  input  logic [1:0]                    s_axis_tuser,  // op[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // heater_on, vent_on, heater_drive,
                                                       // vent_drive, manual_on
  input  logic                          cfg_we_i,
  input  logic [hvwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hvwc_pkg::CfgDataW-1:0] cfg_data_i
);

  hvwc_pkg::cfg_t   cfg;
  hvwc_pkg::word_t  word_q;
  hvwc_pkg::state_t state_q;
  hvwc_pkg::state_t state_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic [4:0]       out_q;
  logic             advance;

  hvwc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hvwc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .word_i  (word_q),
    .state_o (state_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      word_q.op          <= hvwc_pkg::op_e'(s_axis_tuser);
      word_q.temperature <= s_axis_tdata[7:0];
      word_q.humidity    <= s_axis_tdata[14:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hvwc_pkg::StateRst;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= {state_d.manual_mode, state_d.fan_pin, state_d.heater_pin,
                state_d.fan_en, state_d.heat_en};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  a_heater_pin_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.heater_pin |-> state_q.heat_en) else $error("heater pin without enable");
  a_fan_pin_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fan_pin |-> state_q.fan_en) else $error("fan pin without enable");
  a_heater_pend_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.heater_pend |-> state_q.heat_en) else $error("heater pending without enable");
  a_fan_pend_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fan_pend |-> state_q.fan_en) else $error("fan pending without enable");
  a_advance_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid) else $error("processed word lost");

endmodule

>>> hdl/hvwc_cfg_regs.sv
// Configuration register file for the heater and vent window controller.
module hvwc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hvwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hvwc_pkg::CfgDataW-1:0] cfg_data_i,
  output hvwc_pkg::cfg_t                cfg_o
);

  hvwc_pkg::cfg_t   cfg_q;
  hvwc_pkg::cfg_idx_e idx;

  assign idx = hvwc_pkg::cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_humidity    <= hvwc_pkg::MinHumidityRst;
      cfg_q.vent_offset     <= hvwc_pkg::VentOffsetRst;
      cfg_q.vent_window     <= hvwc_pkg::VentWindowRst;
      cfg_q.max_temp_normal <= hvwc_pkg::MaxTempNormRst;
      cfg_q.max_temp_manual <= hvwc_pkg::MaxTempManRst;
      cfg_q.heat_offset     <= hvwc_pkg::HeatOffsetRst;
      cfg_q.heat_window     <= hvwc_pkg::HeatWindowRst;
      cfg_q.hysteresis      <= hvwc_pkg::HysteresisRst;
    end else if (cfg_we_i) begin
      case (idx)
        hvwc_pkg::CFG_MIN_HUMIDITY:  cfg_q.min_humidity    <= cfg_data_i;
        hvwc_pkg::CFG_VENT_OFFSET:   cfg_q.vent_offset     <= cfg_data_i;
        hvwc_pkg::CFG_VENT_WINDOW:   cfg_q.vent_window     <= cfg_data_i;
        hvwc_pkg::CFG_MAX_TEMP_NORM: cfg_q.max_temp_normal <= cfg_data_i;
        hvwc_pkg::CFG_MAX_TEMP_MAN:  cfg_q.max_temp_manual <= cfg_data_i;
        hvwc_pkg::CFG_HEAT_OFFSET:   cfg_q.heat_offset     <= cfg_data_i;
        hvwc_pkg::CFG_HEAT_WINDOW:   cfg_q.heat_window     <= cfg_data_i;
        hvwc_pkg::CFG_HYSTERESIS:    cfg_q.hysteresis      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/hvwc_step.sv
// Next-state logic for one controller word: cutoffs, minute windows, pause and toggle.
module hvwc_step (
  input  hvwc_pkg::cfg_t   cfg_i,
  input  hvwc_pkg::state_t state_i,
  input  hvwc_pkg::word_t  word_i,
  output hvwc_pkg::state_t state_o
);

  logic [8:0]                   heat_end;
  logic [8:0]                   vent_end;
  logic [hvwc_pkg::MinuteW-1:0] count_inc;
  logic [7:0]                   limit_pre;
  logic [7:0]                   limit_post;
  logic [7:0]                   low_temp;
  logic [7:0]                   high_hum;
  logic                         heat_in;
  logic                         vent_in;
  hvwc_pkg::state_t             s;

  assign heat_end  = {1'b0, cfg_i.heat_offset} + {1'b0, cfg_i.heat_window};
  assign vent_end  = {1'b0, cfg_i.vent_offset} + {1'b0, cfg_i.vent_window};
  assign count_inc = state_i.minute_count + 1'b1;
  assign heat_in   = (count_inc <= {1'b0, heat_end}) && (count_inc > {2'b00, cfg_i.heat_offset});
  assign vent_in   = (count_inc <= {1'b0, vent_end}) && (count_inc > {2'b00, cfg_i.vent_offset});
  assign high_hum  = cfg_i.min_humidity + cfg_i.hysteresis;

  always_comb begin
    s = state_i;
    if (word_i.op == hvwc_pkg::OP_SAMPLE) begin
      s.last_temp = word_i.temperature;
      s.last_hum  = word_i.humidity;
    end

    limit_pre = state_i.manual_mode ? cfg_i.max_temp_manual : cfg_i.max_temp_normal;
    low_temp  = limit_pre - cfg_i.hysteresis;

    // first cutoff pass
    if (s.last_temp > limit_pre) begin
      s.heat_en = 1'b0; s.heater_pend = 1'b0; s.heater_pin = 1'b0;
    end
    if (({1'b0, s.last_hum} < cfg_i.min_humidity) && !s.manual_mode) begin
      s.fan_en = 1'b0; s.fan_pend = 1'b0; s.fan_pin = 1'b0;
    end

    case (word_i.op)
      hvwc_pkg::OP_MINUTE: begin
        if (heat_in) begin
          if (s.last_temp < low_temp) begin
            s.heat_en = 1'b1; s.heater_pend = 1'b1;
          end
        end else begin
          s.heat_en = 1'b0; s.heater_pend = 1'b0; s.heater_pin = 1'b0;
        end
        if (vent_in) begin
          if ({1'b0, s.last_hum} > high_hum) begin
            s.fan_en = 1'b1; s.fan_pend = 1'b1;
          end
        end else if (!s.manual_mode) begin
          s.fan_en = 1'b0; s.fan_pend = 1'b0; s.fan_pin = 1'b0;
        end
        if ((count_inc > {1'b0, heat_end}) && (count_inc > {1'b0, vent_end})) begin
          s.minute_count = '0;
        end else begin
          s.minute_count = count_inc;
        end
      end
      hvwc_pkg::OP_PAUSE: begin
        if (s.heater_pend) begin
          s.heater_pin = 1'b1; s.heater_pend = 1'b0;
        end else if (s.fan_pend) begin
          s.fan_pin = 1'b1; s.fan_pend = 1'b0;
        end
      end
      hvwc_pkg::OP_MANUAL: begin
        s.manual_mode = !s.manual_mode;
        if (s.manual_mode) begin
          s.fan_en = 1'b1; s.fan_pend = 1'b1;
        end else begin
          s.fan_en = 1'b0; s.fan_pend = 1'b0; s.fan_pin = 1'b0;
        end
      end
      default: ;
    endcase

    // second cutoff pass, with the mode after the word
    limit_post = s.manual_mode ? cfg_i.max_temp_manual : cfg_i.max_temp_normal;
    if (s.last_temp > limit_post) begin
      s.heat_en = 1'b0; s.heater_pend = 1'b0; s.heater_pin = 1'b0;
    end
    if (({1'b0, s.last_hum} < cfg_i.min_humidity) && !s.manual_mode) begin
      s.fan_en = 1'b0; s.fan_pend = 1'b0; s.fan_pin = 1'b0;
    end

    state_o = s;
  end

endmodule

>>> bench/heater_vent_window_controller_test.sv
// Self-checking bench for the heater and vent window controller, directed and random event words vs. a predictor.
module heater_vent_window_controller_test;

  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic manual_on;
    logic vent_drive;
    logic heater_drive;
    logic vent_on;
    logic heater_on;
  } status_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_STRIDE,
    RX_COIN
  } rx_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // temperature[7:0], humidity[14:8]
  logic [1:0]  s_axis_tuser = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // heater_on, vent_on, heater_drive, vent_drive, manual_on
  logic                          cfg_we_i = 1'b0;
  logic [hvwc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [hvwc_pkg::CfgDataW-1:0] cfg_data_i = '0;

  hvwc_pkg::cfg_t   regs;
  hvwc_pkg::state_t plant;
  hvwc_pkg::word_t  pending_events[$];
  status_t          status_expected[$];
  hvwc_pkg::word_t  drive_word;
  logic             word_taken = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  rx_pattern_e rx_pattern = RX_OPEN;
  int rx_span = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int results_checked = 0;
  int setting_sets = 0;
  int op_seen[4] = '{0, 0, 0, 0};

  heater_vent_window_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] temp_limit();
    return plant.manual_mode ? regs.max_temp_manual : regs.max_temp_normal;
  endfunction

  function automatic void drop_heater();
    plant.heat_en = 1'b0;
    plant.heater_pend = 1'b0;
    plant.heater_pin = 1'b0;
  endfunction

  function automatic void drop_fan();
    plant.fan_en = 1'b0;
    plant.fan_pend = 1'b0;
    plant.fan_pin = 1'b0;
  endfunction

  function automatic void raise_fan();
    plant.fan_en = 1'b1;
    plant.fan_pend = 1'b1;
  endfunction

  function automatic void apply_cutoffs();
    if (plant.last_temp > temp_limit()) drop_heater();
    if ({1'b0, plant.last_hum} < regs.min_humidity && !plant.manual_mode) drop_fan();
  endfunction

  function automatic status_t step_controller(hvwc_pkg::word_t w);
    logic [8:0] heat_end;
    logic [8:0] vent_end;
    logic [7:0] low_temp;
    logic [7:0] high_hum;
    status_t s;
    heat_end = {1'b0, regs.heat_offset} + {1'b0, regs.heat_window};
    vent_end = {1'b0, regs.vent_offset} + {1'b0, regs.vent_window};
    if (w.op == hvwc_pkg::OP_SAMPLE) begin
      plant.last_temp = w.temperature;
      plant.last_hum = w.humidity;
    end
    apply_cutoffs();
    case (w.op)
      hvwc_pkg::OP_MINUTE: begin
        low_temp = temp_limit() - regs.hysteresis;
        high_hum = regs.min_humidity + regs.hysteresis;
        plant.minute_count = plant.minute_count + 1'b1;
        if (plant.minute_count <= heat_end && plant.minute_count > regs.heat_offset) begin
          if (plant.last_temp < low_temp) begin
            plant.heat_en = 1'b1;
            plant.heater_pend = 1'b1;
          end
        end else begin
          drop_heater();
        end
        if (plant.minute_count <= vent_end && plant.minute_count > regs.vent_offset) begin
          if ({1'b0, plant.last_hum} > high_hum) raise_fan();
        end else if (!plant.manual_mode) begin
          drop_fan();
        end
        if (plant.minute_count > heat_end && plant.minute_count > vent_end)
          plant.minute_count = '0;
      end
      hvwc_pkg::OP_PAUSE: begin
        if (plant.heater_pend) begin
          plant.heater_pin = 1'b1;
          plant.heater_pend = 1'b0;
        end else if (plant.fan_pend) begin
          plant.fan_pin = 1'b1;
          plant.fan_pend = 1'b0;
        end
      end
      hvwc_pkg::OP_MANUAL: begin
        plant.manual_mode = !plant.manual_mode;
        if (plant.manual_mode) raise_fan();
        else drop_fan();
      end
      default: begin
      end
    endcase
    apply_cutoffs();
    s.heater_on = plant.heat_en;
    s.vent_on = plant.fan_en;
    s.heater_drive = plant.heater_pin;
    s.vent_drive = plant.fan_pin;
    s.manual_on = plant.manual_mode;
    return s;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endfunction

  // sender: bursts of words with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !word_taken) begin
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_events.size() != 0) begin
      drive_word = pending_events.pop_front();
      s_axis_tuser <= drive_word.op;
      s_axis_tdata <= {1'b0, drive_word.humidity, drive_word.temperature};
      s_axis_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver: random stall pattern, picked anew when its span runs out
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
      rx_span <= $urandom_range(20, 120);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_pattern)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_LIGHT:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_STRIDE: m_axis_tready <= ((rx_span % 4) == 0);
      default:   m_axis_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    hvwc_pkg::word_t taken;
    status_t         want;
    status_t         got;
    word_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken.op = hvwc_pkg::op_e'(s_axis_tuser);
      taken.temperature = s_axis_tdata[7:0];
      taken.humidity = s_axis_tdata[14:8];
      status_expected.push_back(step_controller(taken));
      op_seen[taken.op]++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata[4:0]);
      if (status_expected.size() == 0) begin
        $error("status word %05b arrived with no event outstanding", got);
        mismatches++;
      end else begin
        want = status_expected.pop_front();
        check_field("heater_on", want.heater_on, got.heater_on);
        check_field("vent_on", want.vent_on, got.vent_on);
        check_field("heater_drive", want.heater_drive, got.heater_drive);
        check_field("vent_drive", want.vent_drive, got.vent_drive);
        check_field("manual_on", want.manual_on, got.manual_on);
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(hvwc_pkg::cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      hvwc_pkg::CFG_MIN_HUMIDITY:  regs.min_humidity = val;
      hvwc_pkg::CFG_VENT_OFFSET:   regs.vent_offset = val;
      hvwc_pkg::CFG_VENT_WINDOW:   regs.vent_window = val;
      hvwc_pkg::CFG_MAX_TEMP_NORM: regs.max_temp_normal = val;
      hvwc_pkg::CFG_MAX_TEMP_MAN:  regs.max_temp_manual = val;
      hvwc_pkg::CFG_HEAT_OFFSET:   regs.heat_offset = val;
      hvwc_pkg::CFG_HEAT_WINDOW:   regs.heat_window = val;
      hvwc_pkg::CFG_HYSTERESIS:    regs.hysteresis = val;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (pending_events.size() != 0 || s_axis_tvalid || status_expected.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_event(hvwc_pkg::op_e op, logic [7:0] temp, logic [6:0] hum);
    hvwc_pkg::word_t w;
    w.op = op;
    w.temperature = temp;
    w.humidity = hum;
    pending_events.push_back(w);
  endtask

  task automatic load_all(logic [7:0] val);
    for (int i = 0; i < 8; i++) write_reg(hvwc_pkg::cfg_idx_e'(i), val);
    setting_sets++;
  endtask

  task automatic load_random(bit compact);
    if (compact) begin
      write_reg(hvwc_pkg::CFG_MIN_HUMIDITY, 8'($urandom_range(30, 90)));
      write_reg(hvwc_pkg::CFG_VENT_OFFSET, 8'($urandom_range(0, 12)));
      write_reg(hvwc_pkg::CFG_VENT_WINDOW, 8'($urandom_range(0, 8)));
      write_reg(hvwc_pkg::CFG_MAX_TEMP_NORM, 8'($urandom_range(0, 60)));
      write_reg(hvwc_pkg::CFG_MAX_TEMP_MAN, 8'($urandom_range(0, 60)));
      write_reg(hvwc_pkg::CFG_HEAT_OFFSET, 8'($urandom_range(0, 12)));
      write_reg(hvwc_pkg::CFG_HEAT_WINDOW, 8'($urandom_range(0, 8)));
      write_reg(hvwc_pkg::CFG_HYSTERESIS, 8'($urandom_range(0, 8)));
    end else begin
      for (int i = 0; i < 8; i++)
        write_reg(hvwc_pkg::cfg_idx_e'(i), 8'($urandom_range(0, 255)));
    end
    setting_sets++;
  endtask

  // samples cluster around the live thresholds so that windows and cutoffs both fire
  task automatic queue_random_events(int n);
    int pick;
    int t;
    int h;
    int jit;
    int limit;
    int hyst;
    int floor_hum;
    hvwc_pkg::op_e op;
    @(posedge clk_i);
    hyst = int'(regs.hysteresis);
    floor_hum = int'(regs.min_humidity);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      t = $urandom_range(0, 255);
      h = $urandom_range(0, 100);
      jit = int'($urandom_range(0, 6)) - 3;
      limit = ($urandom_range(0, 1) != 0) ? int'(regs.max_temp_manual)
                                          : int'(regs.max_temp_normal);
      if (pick < 30) begin
        op = hvwc_pkg::OP_SAMPLE;
        case ($urandom_range(0, 2))
          0: t = limit - hyst + jit;
          1: t = limit + jit;
          default: begin
          end
        endcase
        jit = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 2))
          0: h = floor_hum + jit;
          1: h = floor_hum + hyst + jit;
          default: begin
          end
        endcase
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        if (h < 0) h = 0;
        if (h > 100) h = 100;
      end else if (pick < 62) begin
        op = hvwc_pkg::OP_MINUTE;
      end else if (pick < 90) begin
        op = hvwc_pkg::OP_PAUSE;
      end else begin
        op = hvwc_pkg::OP_MANUAL;
      end
      queue_event(op, t[7:0], h[6:0]);
    end
    settle();
  endtask

  initial begin
    regs.min_humidity = 8'd60;
    regs.vent_offset = 8'd10;
    regs.vent_window = 8'd5;
    regs.max_temp_normal = 8'd25;
    regs.max_temp_manual = 8'd30;
    regs.heat_offset = 8'd10;
    regs.heat_window = 8'd5;
    regs.hysteresis = 8'd2;
    plant = '0;
    plant.minute_count = (regs.vent_offset > regs.heat_offset) ? {2'b00, regs.heat_offset}
                                                               : {2'b00, regs.vent_offset};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    setting_sets++;

    // directed pass on the reset settings
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd0, 7'd100);
    queue_event(hvwc_pkg::OP_MINUTE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_PAUSE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_PAUSE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_PAUSE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd255, 7'd0);
    queue_event(hvwc_pkg::OP_MANUAL, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_PAUSE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd28, 7'd50);
    queue_event(hvwc_pkg::OP_MINUTE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_MANUAL, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd20, 7'd70);
    queue_event(hvwc_pkg::OP_MINUTE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd23, 7'd62);
    queue_event(hvwc_pkg::OP_MINUTE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd22, 7'd63);
    queue_event(hvwc_pkg::OP_MINUTE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_PAUSE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_MINUTE, 8'd0, 7'd0);
    queue_event(hvwc_pkg::OP_MINUTE, 8'hFF, 7'h7F);
    queue_event(hvwc_pkg::OP_SAMPLE, 8'd127, 7'd64);
    queue_event(hvwc_pkg::OP_PAUSE, 8'd0, 7'd0);
    settle();

    queue_random_events(230);
    load_all(8'h00);
    queue_random_events(120);
    load_all(8'hFF);
    queue_random_events(120);

    // thresholds that wrap around a byte
    write_reg(hvwc_pkg::CFG_MAX_TEMP_NORM, 8'd1);
    write_reg(hvwc_pkg::CFG_MAX_TEMP_MAN, 8'd3);
    write_reg(hvwc_pkg::CFG_HYSTERESIS, 8'd5);
    write_reg(hvwc_pkg::CFG_MIN_HUMIDITY, 8'd253);
    write_reg(hvwc_pkg::CFG_VENT_OFFSET, 8'd2);
    write_reg(hvwc_pkg::CFG_VENT_WINDOW, 8'd3);
    write_reg(hvwc_pkg::CFG_HEAT_OFFSET, 8'd1);
    write_reg(hvwc_pkg::CFG_HEAT_WINDOW, 8'd4);
    setting_sets++;
    queue_random_events(120);

    for (int p = 0; p < 6; p++) begin
      load_random(1'b1);
      queue_random_events(180);
    end
    for (int p = 0; p < 2; p++) begin
      load_random(1'b0);
      queue_random_events(115);
    end

    $display("Checked %0d status words under %0d register settings", results_checked,
             setting_sets);
    $display("Events: %0d samples, %0d minute ticks, %0d pause ticks, %0d mode toggles",
             op_seen[hvwc_pkg::OP_SAMPLE], op_seen[hvwc_pkg::OP_MINUTE],
             op_seen[hvwc_pkg::OP_PAUSE], op_seen[hvwc_pkg::OP_MANUAL]);
    if (mismatches == 0 && status_expected.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> heater_vent_window_controller.f
hdl/hvwc_pkg.sv
hdl/hvwc_cfg_regs.sv
hdl/hvwc_step.sv
hdl/heater_vent_window_controller.sv
bench/heater_vent_window_controller_test.sv
